FILE: rtl/core/cop_pkg.sv
// shared types, constants and tables for the coupled oscillator phase velocity block
`default_nettype none
package cop_pkg;

   localparam int MAX_OSCILLATORS_DEFAULT = 64;
   localparam int RESULT_LIMIT            = 64;
   localparam int CORDIC_STEPS            = 16;
   localparam int STEP_W                  = 4;
   localparam int DIV_STEPS               = 64;
   localparam int DIV_STEP_W              = 6;
   localparam int ANGLE_W                 = 34;

   localparam logic [23:0] STRENGTH_RESET = 24'd65536;
   localparam logic signed [ANGLE_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic signed [35:0] ONE_Q16 = 36'sd65536;
   localparam logic signed [35:0] VEL_MAX = 36'sd2147483647;
   localparam logic signed [35:0] VEL_MIN = -36'sd2147483648;

   typedef struct packed {
      logic [31:0] phase_hours;
      logic [22:0] period_hours;
      logic        last_oscillator;
   } req_type;

   typedef struct packed {
      logic [5:0]         oscillator_index;
      logic signed [31:0] velocity;
      logic               final_result;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIV,
      ST_VSTART,
      ST_VDIV,
      ST_READ,
      ST_CSTART,
      ST_COS,
      ST_MULT,
      ST_VEL,
      ST_EMIT
   } state_type;

   // arctan(2^-i) in Q2.30 radians
   function automatic logic signed [ANGLE_W-1:0] arc_angle(input logic [STEP_W-1:0] i);
      logic signed [ANGLE_W-1:0] a;
      begin
         case (i)
            4'd0:    a = 34'sh03243F6A8;
            4'd1:    a = 34'sh01DAC6705;
            4'd2:    a = 34'sh00FADBAFC;
            4'd3:    a = 34'sh007F56EA6;
            4'd4:    a = 34'sh003FEAB76;
            4'd5:    a = 34'sh001FFD55B;
            4'd6:    a = 34'sh000FFFAAA;
            4'd7:    a = 34'sh0007FFF55;
            4'd8:    a = 34'sh0003FFFEA;
            4'd9:    a = 34'sh0001FFFFD;
            4'd10:   a = 34'sh0000FFFFF;
            4'd11:   a = 34'sh00007FFFF;
            4'd12:   a = 34'sh00003FFFF;
            4'd13:   a = 34'sh00001FFFF;
            4'd14:   a = 34'sh00000FFFF;
            default: a = 34'sh000007FFF;
         endcase
         return a;
      end
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cop_divider.sv
// restoring divider, one quotient bit per cycle over a 64-bit dividend
`default_nettype none
module cop_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] dividend,
   input  wire logic [22:0] divisor,
   output logic             done,
   output logic [31:0]      quotient,
   output logic [22:0]      mid_remainder
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [cop_pkg::DIV_STEP_W-1:0] step_ff, step_in;
   logic [63:0]                    dvd_ff, dvd_in;
   logic [22:0]                    dsr_ff, dsr_in;
   logic [22:0]                    rem_ff, rem_in;
   logic [31:0]                    quo_ff, quo_in;
   logic [22:0]                    mid_ff, mid_in;
   logic [23:0]                    trial;
   logic                           fits;

   assign trial = {rem_ff, dvd_ff[63]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      mid_in  = mid_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = fits ? 23'(trial - {1'b0, dsr_ff}) : trial[22:0];
         quo_in  = {quo_ff[30:0], fits};
         dvd_in  = {dvd_ff[62:0], 1'b0};
         step_in = step_ff + 1'b1;
         // remainder of the integer part once the upper half is consumed
         if (step_ff == cop_pkg::DIV_STEP_W'(cop_pkg::DIV_STEPS / 2 - 1)) begin
            mid_in = rem_in;
         end
         if (step_ff == cop_pkg::DIV_STEP_W'(cop_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      mid_ff  <= mid_in;
   end

   assign done          = done_ff;
   assign quotient      = quo_ff;
   assign mid_remainder = mid_ff;

endmodule
`default_nettype wire

FILE: rtl/core/cop_cordic.sv
// iterative cordic giving cos(2*pi*r) for a fraction of a turn, one rotation per cycle
`default_nettype none
module cop_cordic (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [31:0]       turn,
   output logic                   done,
   output logic signed [cop_pkg::ANGLE_W-1:0] cosine
);

   localparam int W = cop_pkg::ANGLE_W;

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [cop_pkg::STEP_W-1:0] step_ff, step_in;
   logic [1:0]                 quad_ff, quad_in;
   logic signed [W-1:0]        x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [W-1:0]        dx, dy, arc;
   logic [60:0]                angle_prod;

   assign angle_prod = {31'd0, turn[29:0]} * {30'd0, cop_pkg::HALF_PI_Q30};
   assign dx  = y_ff >>> step_ff;
   assign dy  = x_ff >>> step_ff;
   assign arc = cop_pkg::arc_angle(step_ff);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quad_in = quad_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quad_in = turn[31:30];
         x_in    = cop_pkg::CORDIC_GAIN;
         y_in    = '0;
         z_in    = W'(angle_prod[60:30]);
      end else if (busy_ff) begin
         if (z_ff >= 0) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - arc;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + arc;
         end
         step_in = step_ff + 1'b1;
         if (step_ff == cop_pkg::STEP_W'(cop_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quad_ff <= quad_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
   end

   always_comb begin
      case (quad_ff)
         2'd0:    cosine = x_ff;
         2'd1:    cosine = -y_ff;
         2'd2:    cosine = -x_ff;
         default: cosine = y_ff;
      endcase
   end

   assign done = done_ff;

endmodule
`default_nettype wire

FILE: rtl/core/coupled_oscillator_phase_velocity.sv
// top level: load sequencer, fraction store and velocity emission
// Each loaded oscillator with a nonzero period gets its cycle fraction from a
// restoring divider that yields one bit a cycle over a 64-bit dividend (a zero
// period stores a zero fraction), and the block takes one item at a time. An item
// not marked last produces nothing. The item marked last also runs the mean
// coupling division; then each result is read from the fraction store and runs
// through a 16-step cordic and a multiply, and waits for rsp_ready. No input is
// taken while results are being delivered. The store holds up to
// min(MAX_OSCILLATORS, 64) oscillators; items beyond that are dropped, though a
// last mark on them still ends the set. Counts clear after the last result.
`default_nettype none
module coupled_oscillator_phase_velocity #(
   parameter int MAX_OSCILLATORS = cop_pkg::MAX_OSCILLATORS_DEFAULT
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire cop_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output cop_pkg::rsp_type     rsp_data,
   input  wire logic            csr_wr_en,
   input  wire logic [23:0]     csr_wr_data
);

   localparam int CAP   = (MAX_OSCILLATORS < cop_pkg::RESULT_LIMIT) ?
                          MAX_OSCILLATORS : cop_pkg::RESULT_LIMIT;
   localparam int IDX_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CNT_W = $clog2(CAP + 1);

   cop_pkg::state_type state_ff, state_in;

   logic [23:0]        strength_ff;
   cop_pkg::req_type   item_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   window_ff, window_in;
   logic [IDX_W-1:0]   k_ff, k_in;
   logic [30:0]        coupling_ff;
   logic signed [65:0] prod_ff;
   cop_pkg::rsp_type   rsp_ff;

   logic [31:0]        store [CAP];
   logic [31:0]        rd_data_ff;
   logic               store_we;
   logic [31:0]        store_wdata;

   logic               div_start, div_done;
   logic [63:0]        div_dividend;
   logic [22:0]        div_divisor;
   logic [31:0]        div_quotient;
   logic [22:0]        div_rem;
   logic               cos_start, cos_done;
   logic signed [cop_pkg::ANGLE_W-1:0] cos_value;

   logic               store_full, period_zero, in_window, last_result;
   logic [30:0]        strength_mul;
   logic signed [35:0] scaled, vel_sum;
   logic [31:0]        vel_sat;

   assign store_full  = count_ff >= CNT_W'(CAP);
   assign period_zero = item_ff.period_hours == '0;
   assign in_window   = ({3'd0, div_rem} * 26'd6 >= {3'd0, item_ff.period_hours}) &&
                        ({3'd0, div_rem} * 26'd3 <= {3'd0, item_ff.period_hours});
   assign last_result = (CNT_W'(k_ff) + 1'b1) == count_ff;
   assign strength_mul = 31'(strength_ff * {{(24 - CNT_W){1'b0}}, window_ff});

   assign div_dividend = (state_ff == cop_pkg::ST_LOAD) ? {item_ff.phase_hours, 32'd0}
                                                         : {33'd0, strength_mul};
   assign div_divisor  = (state_ff == cop_pkg::ST_LOAD) ? item_ff.period_hours
                                                         : 23'(count_ff);

   cop_divider u_div (
      .clock         (clock),
      .reset         (reset),
      .start         (div_start),
      .dividend      (div_dividend),
      .divisor       (div_divisor),
      .done          (div_done),
      .quotient      (div_quotient),
      .mid_remainder (div_rem)
   );

   cop_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cos_start),
      .turn   (rd_data_ff),
      .done   (cos_done),
      .cosine (cos_value)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cop_pkg::ST_IDLE: begin
            if (req_valid) state_in = cop_pkg::ST_LOAD;
         end
         cop_pkg::ST_LOAD: begin
            if (!store_full && !period_zero) begin
               state_in = cop_pkg::ST_DIV;
            end else if (item_ff.last_oscillator) begin
               state_in = cop_pkg::ST_VSTART;
            end else begin
               state_in = cop_pkg::ST_IDLE;
            end
         end
         cop_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = item_ff.last_oscillator ? cop_pkg::ST_VSTART : cop_pkg::ST_IDLE;
            end
         end
         cop_pkg::ST_VSTART: state_in = cop_pkg::ST_VDIV;
         cop_pkg::ST_VDIV: begin
            if (div_done) state_in = cop_pkg::ST_READ;
         end
         cop_pkg::ST_READ:   state_in = cop_pkg::ST_CSTART;
         cop_pkg::ST_CSTART: state_in = cop_pkg::ST_COS;
         cop_pkg::ST_COS: begin
            if (cos_done) state_in = cop_pkg::ST_MULT;
         end
         cop_pkg::ST_MULT: state_in = cop_pkg::ST_VEL;
         cop_pkg::ST_VEL:  state_in = cop_pkg::ST_EMIT;
         cop_pkg::ST_EMIT: begin
            if (rsp_ready) state_in = last_result ? cop_pkg::ST_IDLE : cop_pkg::ST_READ;
         end
         default: state_in = cop_pkg::ST_IDLE;
      endcase
   end

   // outputs and strobes
   always_comb begin
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      div_start   = 1'b0;
      cos_start   = 1'b0;
      store_we    = 1'b0;
      store_wdata = div_quotient;
      count_in    = count_ff;
      window_in   = window_ff;
      k_in        = k_ff;
      case (state_ff)
         cop_pkg::ST_IDLE: req_ready = 1'b1;
         cop_pkg::ST_LOAD: begin
            if (!store_full) begin
               if (period_zero) begin
                  store_we    = 1'b1;
                  store_wdata = '0;
                  count_in    = count_ff + 1'b1;
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         cop_pkg::ST_DIV: begin
            if (div_done) begin
               store_we = 1'b1;
               count_in = count_ff + 1'b1;
               if (in_window) window_in = window_ff + 1'b1;
            end
         end
         cop_pkg::ST_VSTART: begin
            div_start = 1'b1;
            k_in      = '0;
         end
         cop_pkg::ST_CSTART: cos_start = 1'b1;
         cop_pkg::ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (last_result) begin
                  count_in  = '0;
                  window_in = '0;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   // round v*cos from Q.46 to Q16.16, add one, saturate
   assign scaled  = 36'((prod_ff + 66'sd536870912) >>> 30);
   assign vel_sum = scaled + cop_pkg::ONE_Q16;
   assign vel_sat = (vel_sum > cop_pkg::VEL_MAX) ? 32'h7FFF_FFFF :
                    (vel_sum < cop_pkg::VEL_MIN) ? 32'h8000_0000 : vel_sum[31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= cop_pkg::ST_IDLE;
         strength_ff <= cop_pkg::STRENGTH_RESET;
         count_ff    <= '0;
         window_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         window_ff <= window_in;
         if (csr_wr_en) strength_ff <= csr_wr_data;
      end
      k_ff <= k_in;
      if (req_valid && req_ready) item_ff <= req_data;
      if (state_ff == cop_pkg::ST_VDIV && div_done) coupling_ff <= div_quotient[30:0];
      if (state_ff == cop_pkg::ST_MULT) begin
         prod_ff <= $signed({1'b0, coupling_ff}) * cos_value;
      end
      if (state_ff == cop_pkg::ST_VEL) begin
         rsp_ff.oscillator_index <= 6'(k_ff);
         rsp_ff.velocity         <= vel_sat;
         rsp_ff.final_result     <= last_result;
      end
   end

   // fraction store, one write and one registered read
   always_ff @(posedge clock) begin
      if (store_we) store[count_ff[IDX_W-1:0]] <= store_wdata;
      rd_data_ff <= store[k_ff];
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

FILE: bench/coupled_oscillator_phase_velocity_tb.sv
// testbench for the coupled oscillator phase velocity block
`timescale 1ns / 1ps
module coupled_oscillator_phase_velocity_tb;

   localparam int CAPACITY = 64;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   cop_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   cop_pkg::rsp_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [23:0] csr_wr_data = '0;

   coupled_oscillator_phase_velocity u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #2 clock = ~clock;

   // predictor state
   logic [23:0] strength = cop_pkg::STRENGTH_RESET;
   logic [31:0] fraction_store [CAPACITY];
   int unsigned loaded_count = 0;
   int unsigned window_count = 0;

   cop_pkg::req_type pending_items [$];
   cop_pkg::rsp_type expected_velocities [$];
   int errors = 0;
   int cycle_count = 0;
   int send_wait = 0;
   int recv_wait = 0;
   // transfers seen at the last rising edge
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint turn_cos(logic [31:0] r);
      longint x, y, z, dx, dy;
      longint unsigned f;
      f = {34'd0, r[29:0]};
      z = longint'((f * 64'd1686629713) >> 30);
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(cop_pkg::arc_angle(i[3:0]));
         end else begin
            x += dx; y -= dy; z += longint'(cop_pkg::arc_angle(i[3:0]));
         end
      end
      case (r[31:30])
         2'd0: return x;
         2'd1: return -y;
         2'd2: return -x;
         default: return y;
      endcase
   endfunction

   task automatic predict_velocities(cop_pkg::req_type item);
      longint unsigned rem, per;
      longint v, prod, vel;
      logic [31:0] r;
      cop_pkg::rsp_type e;
      if (loaded_count < CAPACITY) begin
         r = '0;
         per = item.period_hours;
         if (per != 0) begin
            rem = item.phase_hours % per;
            r = 32'((rem << 32) / per);
            if (6 * rem >= per && 3 * rem <= per) window_count++;
         end
         fraction_store[loaded_count] = r;
         loaded_count++;
      end
      if (item.last_oscillator) begin
         if (loaded_count != 0) begin
            v = longint'((longint'(strength) * window_count) / loaded_count);
            for (int k = 0; k < loaded_count; k++) begin
               prod = floor_shr(v * turn_cos(fraction_store[k]) + (64'sd1 <<< 29), 30);
               vel = prod + 65536;
               if (vel > 64'sd2147483647) vel = 64'sd2147483647;
               if (vel < -64'sd2147483648) vel = -64'sd2147483648;
               e.oscillator_index = k[5:0];
               e.velocity = vel[31:0];
               e.final_result = (k + 1 == loaded_count);
               expected_velocities.push_back(e);
            end
         end
         loaded_count = 0;
         window_count = 0;
      end
   endtask

   // driver
   always @(negedge clock) begin
      int draw;
      if (!reset) begin
         if (req_valid && !req_fire) begin
            // hold until the transfer
         end else if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (pending_items.size() > 0) begin
            req_data <= pending_items.pop_front();
            req_valid <= 1'b1;
            send_wait <= $urandom_range(0, 11);
         end else begin
            req_valid <= 1'b0;
         end
         if (recv_wait > 0) begin
            rsp_ready <= 1'b0;
            recv_wait <= recv_wait - 1;
         end else if (rsp_fire) begin
            draw = $urandom_range(0, 11);
            rsp_ready <= (draw == 0);
            recv_wait <= (draw > 0) ? draw - 1 : 0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      req_fire <= !reset && req_valid && req_ready;
      rsp_fire <= !reset && rsp_valid && rsp_ready;
      if (!reset && req_valid && req_ready) predict_velocities(req_data);
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_velocities.size() == 0) begin
            $display("%0t: unexpected transfer %h", $time, rsp_data);
            errors++;
         end else begin
            cop_pkg::rsp_type e;
            e = expected_velocities.pop_front();
            if (e.oscillator_index != rsp_data.oscillator_index)
               $display("%0t: index expected %0d actual %0d", $time,
                        e.oscillator_index, rsp_data.oscillator_index);
            if (e.velocity != rsp_data.velocity)
               $display("%0t: velocity expected %h actual %h", $time,
                        e.velocity, rsp_data.velocity);
            if (e.final_result != rsp_data.final_result)
               $display("%0t: final expected %b actual %b", $time,
                        e.final_result, rsp_data.final_result);
            if (e != rsp_data) errors++;
         end
      end
   end

   function automatic cop_pkg::req_type make_item(logic last);
      cop_pkg::req_type it;
      int mode;
      mode = $urandom_range(0, 9);
      it.phase_hours = $urandom();
      case (mode)
         0: it.period_hours = 23'd65536;
         1: it.period_hours = 23'd6553600;
         2: it.period_hours = 23'($urandom());
         3: it.period_hours = 23'd0;
         default: it.period_hours = 23'($urandom_range(65536, 6553600));
      endcase
      if ($urandom_range(0, 3) == 0)
         // land in the release window: hour 4 to 8 of the cycle
         it.phase_hours = $urandom_range(0, 1000) * it.period_hours
                          + it.period_hours * $urandom_range(4, 8) / 24;
      it.last_oscillator = last;
      return it;
   endfunction

   task automatic drain();
      while (pending_items.size() > 0 || req_valid || expected_velocities.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_strength(logic [23:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      strength = value;
   endtask

   task automatic queue_set(int n);
      for (int i = 0; i < n; i++) pending_items.push_back(make_item(i == n - 1));
   endtask

   initial begin
      cop_pkg::req_type it;
      int sent, n;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, zero period, window edges, reset strength
      it = '{32'hFFFFFFFF, 23'd6553600, 1'b0}; pending_items.push_back(it);
      it = '{32'd0, 23'd65536, 1'b0}; pending_items.push_back(it);
      it = '{32'h12345678, 23'd0, 1'b0}; pending_items.push_back(it);
      it = '{32'd24, 23'd144, 1'b0}; pending_items.push_back(it);   // hour 4 exactly
      it = '{32'd48, 23'd144, 1'b0}; pending_items.push_back(it);   // hour 8 exactly
      it = '{32'd23, 23'd144, 1'b0}; pending_items.push_back(it);
      it = '{32'd49, 23'd144, 1'b0}; pending_items.push_back(it);
      it = '{32'hFFFFFFFF, 23'h7FFFFF, 1'b1}; pending_items.push_back(it);
      it = '{32'd5, 23'd0, 1'b1}; pending_items.push_back(it);       // set of one, zero period
      drain();

      write_strength(24'hFFFFFF);
      for (int i = 0; i < 3; i++) begin
         it = '{32'd30, 23'd144, 1'b0}; pending_items.push_back(it);
      end
      it = '{32'd36, 23'd144, 1'b1}; pending_items.push_back(it);
      drain();

      // overfilled store: dropped items, last still ends the set
      write_strength(24'd0);
      queue_set(70);
      drain();

      sent = 0;
      while (sent < 220) begin
         case ($urandom_range(0, 3))
            0: write_strength(24'($urandom()));
            1: write_strength(24'hFFFFFF);
            2: write_strength(24'($urandom_range(0, 262144)));
            default: ;
         endcase
         for (int s = 0; s < 5; s++) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
            queue_set(n);
            sent += n;
         end
         drain();
      end

      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

FILE: sim.f
rtl/core/cop_pkg.sv
rtl/core/cop_divider.sv
rtl/core/cop_cordic.sv
rtl/core/coupled_oscillator_phase_velocity.sv
bench/coupled_oscillator_phase_velocity_tb.sv
